### rtl/lav_pkg.sv
// Shared types, constants and helper functions of the look-at view matrix block.
package lav_pkg;

   localparam int FRAC_BITS = 16;
   localparam int UNIT_W = FRAC_BITS + 2;
   localparam int AXIS_W = 18;
   localparam int NUM_W = FRAC_BITS + 31;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int SQRT_STEPS = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam longint AXIS_MAX = (64'sd1 <<< (AXIS_W - 1)) - 64'sd1;
   localparam longint AXIS_MIN = -AXIS_MAX - 64'sd1;
   localparam longint OFFSET_MAX = 64'sd2147483647;
   localparam longint OFFSET_MIN = -64'sd2147483648;

   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP = 2'd1;
   localparam logic [1:0] ROW_BACK = 2'd2;

   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      logic [2:0][31:0] eye;
      logic [2:0][31:0] up;
      logic [2:0][32:0] zv;
      logic zero;
   } item_type;

   typedef struct packed {
      logic [1:0] row_index;
      logic [AXIS_W-1:0] axis_x;
      logic [AXIS_W-1:0] axis_y;
      logic [AXIS_W-1:0] axis_z;
      logic [31:0] offset;
      logic degenerate;
      logic last;
   } row_type;

   typedef struct packed {
      logic done;
      logic ok;
   } norm_status_type;

   typedef enum logic [3:0] {
      N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SQRT, N_DLOAD, N_DIV, N_DSTORE, N_DONE
   } norm_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_ZGO, B_ZWAIT, B_XMUL, B_XACC, B_XGO, B_XWAIT,
      B_YMUL, B_YACC, B_YGO, B_YWAIT, B_OMUL, B_OACC, B_EMIT
   } back_state_type;

   function automatic logic [AXIS_W-1:0] axis_sat(unit_type u);
      wide_type v;
      v = 64'(u);
      if (v > AXIS_MAX) v = AXIS_MAX;
      if (v < AXIS_MIN) v = AXIS_MIN;
      return v[AXIS_W-1:0];
   endfunction

   // Round to nearest with ties upward, negate, then clamp to 32 bits.
   function automatic logic [31:0] offset_round(wide_type s);
      wide_type t;
      wide_type r;
      t = s + (64'sd1 <<< (FRAC_BITS - 1));
      r = -(t >>> FRAC_BITS);
      if (r > OFFSET_MAX) r = OFFSET_MAX;
      if (r < OFFSET_MIN) r = OFFSET_MIN;
      return r[31:0];
   endfunction

endpackage

### rtl/lav_front.sv
// Front end: accepts request beats, forms eye minus target and flags a zero Z.
module lav_front import lav_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] eye_x,
   input  logic [31:0] eye_y,
   input  logic [31:0] eye_z,
   input  logic [31:0] target_x,
   input  logic [31:0] target_y,
   input  logic [31:0] target_z,
   input  logic [31:0] up_x,
   input  logic [31:0] up_y,
   input  logic [31:0] up_z,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_take
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   entry;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      entry.eye = {eye_z, eye_y, eye_x};
      entry.up = {up_z, up_y, up_x};
      entry.zv[0] = {eye_x[31], eye_x} - {target_x[31], target_x};
      entry.zv[1] = {eye_y[31], eye_y} - {target_y[31], target_y};
      entry.zv[2] = {eye_z[31], eye_z} - {target_z[31], target_z};
      entry.zero = (eye_x == target_x) && (eye_y == target_y) && (eye_z == target_z);
   end

   assign full = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item = q_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### rtl/lav_norm.sv
// Iterative vector normalizer: range shift, sum of squares, square root, division.
module lav_norm import lav_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  wide_type        vec_x,
   input  wide_type        vec_y,
   input  wide_type        vec_z,
   output norm_status_type status,
   output unit_type        unit_x,
   output unit_type        unit_y,
   output unit_type        unit_z
);

   norm_state_type   state_ff, state_in;
   logic [63:0]      m_ff [3];
   logic [2:0]       neg_ff;
   logic [63:0]      mx_ff;
   logic [59:0]      sq_ff;
   logic [63:0]      sum_ff;
   logic [63:0]      res_ff;
   logic [63:0]      bit_ff;
   logic [1:0]       idx_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [30:0]      rem_ff;
   logic             ok_ff;
   unit_type         unit_ff [3];
   logic [63:0]      m_sel;
   logic [63:0]      mx_next;
   logic [63:0]      trial;
   logic [31:0]      dtrial;
   logic [31:0]      dlen;
   logic             dge;
   logic             in_range;
   unit_type         q_unit;

   assign in_range = (mx_ff[63:30] == 34'd0) && mx_ff[29];

   always_comb begin
      case (idx_ff)
         2'd0: m_sel = m_ff[0];
         2'd1: m_sel = m_ff[1];
         2'd2: m_sel = m_ff[2];
         default: m_sel = '0;
      endcase
   end

   always_comb begin
      mx_next = m_ff[0];
      if (m_ff[1] > mx_next) mx_next = m_ff[1];
      if (m_ff[2] > mx_next) mx_next = m_ff[2];
   end

   assign trial = res_ff + bit_ff;
   assign dtrial = {rem_ff, num_ff[NUM_W-1]};
   assign dlen = {1'b0, res_ff[30:0]};
   assign dge = (dtrial >= dlen);
   assign q_unit = unit_type'({1'b0, quo_ff[UNIT_W-2:0]});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         N_IDLE:   if (start) state_in = N_MAX;
         N_MAX:    state_in = N_SHIFT;
         N_SHIFT: begin
            if (mx_ff == 64'd0) state_in = N_DONE;
            else if (in_range) state_in = N_SQ;
         end
         N_SQ:     if (idx_ff == 2'd3) state_in = N_SQRT;
         N_SQRT:   if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = N_DLOAD;
         N_DLOAD:  state_in = N_DIV;
         N_DIV:    if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = N_DSTORE;
         N_DSTORE: state_in = (idx_ff == 2'd2) ? N_DONE : N_DLOAD;
         N_DONE:   state_in = N_IDLE;
         default:  state_in = N_IDLE;
      endcase
   end

   always_comb begin
      status.done = (state_ff == N_DONE);
      status.ok = ok_ff;
      unit_x = unit_ff[0];
      unit_y = unit_ff[1];
      unit_z = unit_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               m_ff[0] <= vec_x[63] ? 64'(-vec_x) : 64'(vec_x);
               m_ff[1] <= vec_y[63] ? 64'(-vec_y) : 64'(vec_y);
               m_ff[2] <= vec_z[63] ? 64'(-vec_z) : 64'(vec_z);
               neg_ff <= {vec_z[63], vec_y[63], vec_x[63]};
            end
         end
         N_MAX: mx_ff <= mx_next;
         N_SHIFT: begin
            ok_ff <= (mx_ff != 64'd0);
            idx_ff <= 2'd0;
            sum_ff <= 64'd0;
            // One bit per beat until the largest magnitude sits in [2^29, 2^30).
            if (mx_ff[63:30] != 34'd0) begin
               mx_ff <= mx_ff >> 1;
               m_ff[0] <= m_ff[0] >> 1;
               m_ff[1] <= m_ff[1] >> 1;
               m_ff[2] <= m_ff[2] >> 1;
            end else if (!mx_ff[29] && (mx_ff != 64'd0)) begin
               mx_ff <= mx_ff << 1;
               m_ff[0] <= m_ff[0] << 1;
               m_ff[1] <= m_ff[1] << 1;
               m_ff[2] <= m_ff[2] << 1;
            end
         end
         N_SQ: begin
            if (idx_ff != 2'd3) sq_ff <= m_sel[29:0] * m_sel[29:0];
            if (idx_ff != 2'd0) sum_ff <= sum_ff + 64'(sq_ff);
            idx_ff <= idx_ff + 2'd1;
            res_ff <= 64'd0;
            bit_ff <= 64'd1 << 62;
            cnt_ff <= '0;
         end
         N_SQRT: begin
            if (sum_ff >= trial) begin
               sum_ff <= sum_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= (cnt_ff == CNT_W'(SQRT_STEPS - 1)) ? '0 : cnt_ff + 1'b1;
         end
         N_DLOAD: begin
            num_ff <= NUM_W'({m_sel[29:0], {FRAC_BITS{1'b0}}}) + NUM_W'(res_ff[30:1]);
            rem_ff <= 31'd0;
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         N_DIV: begin
            rem_ff <= dge ? 31'(dtrial - dlen) : dtrial[30:0];
            num_ff <= num_ff << 1;
            quo_ff <= {quo_ff[NUM_W-2:0], dge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         N_DSTORE: begin
            unit_ff[idx_ff] <= neg_ff[idx_ff] ? -q_unit : q_unit;
            idx_ff <= idx_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/lav_back.sv
// Back end: sequences the cross products, normalizations and row offsets.
module lav_back import lav_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  item_type        item,
   output logic            item_take,
   output logic            norm_start,
   output wide_type        norm_x,
   output wide_type        norm_y,
   output wide_type        norm_z,
   input  norm_status_type norm_status,
   input  unit_type        unit_x,
   input  unit_type        unit_y,
   input  unit_type        unit_z,
   output logic            row_push,
   output row_type         row,
   input  logic            queue_full
);

   back_state_type state_ff, state_in;
   item_type       cur_ff;
   unit_type       ax0_ff [3];
   unit_type       ax1_ff [3];
   unit_type       ax2_ff [3];
   wide_type       vec_ff [3];
   wide_type       prod_ff;
   wide_type       acc_ff;
   logic [2:0]     term_ff;
   logic [1:0]     row_ff;
   logic           deg_ff;
   logic [1:0]     ai;
   logic [1:0]     bi;
   logic signed [31:0] mul_a;
   unit_type       mul_b;
   logic signed [31+UNIT_W:0] mul_p;
   unit_type       row_ax [3];

   // Operand pairs for the six partial products of a cross product.
   always_comb begin
      ai = 2'd0;
      bi = 2'd0;
      case (term_ff)
         3'd0: begin ai = 2'd1; bi = 2'd2; end
         3'd1: begin ai = 2'd2; bi = 2'd1; end
         3'd2: begin ai = 2'd2; bi = 2'd0; end
         3'd3: begin ai = 2'd0; bi = 2'd2; end
         3'd4: begin ai = 2'd0; bi = 2'd1; end
         3'd5: begin ai = 2'd1; bi = 2'd0; end
         default: begin ai = 2'd0; bi = 2'd0; end
      endcase
   end

   always_comb begin
      case (row_ff)
         ROW_RIGHT: row_ax = ax0_ff;
         ROW_UP:    row_ax = ax1_ff;
         default:   row_ax = ax2_ff;
      endcase
   end

   always_comb begin
      case (state_ff)
         B_XMUL: begin
            mul_a = $signed(cur_ff.up[ai]);
            mul_b = ax2_ff[bi];
         end
         B_YMUL: begin
            mul_a = 32'(ax2_ff[ai]);
            mul_b = ax0_ff[bi];
         end
         default: begin
            mul_a = $signed(cur_ff.eye[term_ff[1:0]]);
            mul_b = row_ax[term_ff[1:0]];
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (item_valid) state_in = item.zero ? B_EMIT : B_ZGO;
         B_ZGO:   state_in = B_ZWAIT;
         B_ZWAIT: if (norm_status.done) state_in = norm_status.ok ? B_XMUL : B_EMIT;
         B_XMUL:  state_in = B_XACC;
         B_XACC:  state_in = (term_ff == 3'd5) ? B_XGO : B_XMUL;
         B_XGO:   state_in = B_XWAIT;
         B_XWAIT: if (norm_status.done) state_in = norm_status.ok ? B_YMUL : B_EMIT;
         B_YMUL:  state_in = B_YACC;
         B_YACC:  state_in = (term_ff == 3'd5) ? B_YGO : B_YMUL;
         B_YGO:   state_in = B_YWAIT;
         B_YWAIT: if (norm_status.done) state_in = norm_status.ok ? B_OMUL : B_EMIT;
         B_OMUL:  state_in = B_OACC;
         B_OACC:  state_in = (term_ff == 3'd2) ? B_EMIT : B_OMUL;
         B_EMIT: begin
            if (!queue_full) begin
               if (row_ff == ROW_BACK) state_in = B_IDLE;
               else state_in = deg_ff ? B_EMIT : B_OMUL;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      item_take = (state_ff == B_IDLE) && item_valid;
      norm_start = (state_ff == B_ZGO) || (state_ff == B_XGO) || (state_ff == B_YGO);
      row_push = (state_ff == B_EMIT) && !queue_full;
      if (state_ff == B_ZGO) begin
         norm_x = 64'($signed(cur_ff.zv[0]));
         norm_y = 64'($signed(cur_ff.zv[1]));
         norm_z = 64'($signed(cur_ff.zv[2]));
      end else begin
         norm_x = vec_ff[0];
         norm_y = vec_ff[1];
         norm_z = vec_ff[2];
      end
      row.row_index = row_ff;
      row.degenerate = deg_ff;
      row.last = (row_ff == ROW_BACK);
      if (deg_ff) begin
         row.axis_x = '0;
         row.axis_y = '0;
         row.axis_z = '0;
         row.offset = 32'd0;
      end else begin
         row.axis_x = axis_sat(row_ax[0]);
         row.axis_y = axis_sat(row_ax[1]);
         row.axis_z = axis_sat(row_ax[2]);
         row.offset = offset_round(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (item_valid) begin
               cur_ff <= item;
               deg_ff <= item.zero;
               row_ff <= ROW_RIGHT;
               term_ff <= 3'd0;
            end
         end
         B_ZWAIT: begin
            if (norm_status.done) begin
               ax2_ff[0] <= unit_x;
               ax2_ff[1] <= unit_y;
               ax2_ff[2] <= unit_z;
               deg_ff <= !norm_status.ok;
            end
         end
         B_XWAIT: begin
            if (norm_status.done) begin
               ax0_ff[0] <= unit_x;
               ax0_ff[1] <= unit_y;
               ax0_ff[2] <= unit_z;
               deg_ff <= !norm_status.ok;
            end
         end
         B_YWAIT: begin
            if (norm_status.done) begin
               ax1_ff[0] <= unit_x;
               ax1_ff[1] <= unit_y;
               ax1_ff[2] <= unit_z;
               deg_ff <= !norm_status.ok;
            end
         end
         B_XMUL, B_YMUL, B_OMUL: prod_ff <= 64'(mul_p);
         B_XACC, B_YACC: begin
            // Even terms open a component, odd terms subtract and close it.
            if (!term_ff[0]) acc_ff <= prod_ff;
            else vec_ff[term_ff[2:1]] <= acc_ff - prod_ff;
            term_ff <= (term_ff == 3'd5) ? 3'd0 : term_ff + 3'd1;
         end
         B_OACC: begin
            acc_ff <= ((term_ff == 3'd0) ? 64'sd0 : acc_ff) + prod_ff;
            term_ff <= (term_ff == 3'd2) ? 3'd0 : term_ff + 3'd1;
         end
         B_EMIT: begin
            if (!queue_full) row_ff <= row_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/lav_rspq.sv
// Result queue holding finished rows until the consumer pops them.
module lav_rspq import lav_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    row_push,
   input  row_type row_in,
   output logic    queue_full,
   input  logic    pop,
   output logic    empty,
   output row_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   row_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_pop;

   assign queue_full = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = q_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = row_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (PTR_W + 1)'(row_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (row_push) begin
         q_ff[wr_ptr_ff] <= row_in;
      end
   end

endmodule

### rtl/look_at_view_matrix.sv
// Top level of the look-at view matrix block.
//
//   channel   handshake      payload
//   request   push / full    req_eye_*, req_target_*, req_up_*
//   result    empty / pop    rsp_row_index, rsp_axis_*, rsp_offset, rsp_degenerate, rsp_last
//
// Each request beat yields three result beats, rows 0, 1 and 2 in that order.
// The single shared normalize unit sets the pace: per vector a range shift, a
// 32-step square root and, per component, a 47-step divide. An eye equal to the
// target skips the normalize unit. The front holds two requests and the result
// queue four rows, so either side may stall without at once blocking the other.
// Reset is synchronous and empties both.
module look_at_view_matrix import lav_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [31:0]       req_eye_x,
   input  logic [31:0]       req_eye_y,
   input  logic [31:0]       req_eye_z,
   input  logic [31:0]       req_target_x,
   input  logic [31:0]       req_target_y,
   input  logic [31:0]       req_target_z,
   input  logic [31:0]       req_up_x,
   input  logic [31:0]       req_up_y,
   input  logic [31:0]       req_up_z,
   output logic              empty,
   input  logic              pop,
   output logic [1:0]        rsp_row_index,
   output logic [AXIS_W-1:0] rsp_axis_x,
   output logic [AXIS_W-1:0] rsp_axis_y,
   output logic [AXIS_W-1:0] rsp_axis_z,
   output logic [31:0]       rsp_offset,
   output logic              rsp_degenerate,
   output logic              rsp_last
);

   logic            item_valid;
   item_type        item;
   logic            item_take;
   logic            norm_start;
   wide_type        norm_x, norm_y, norm_z;
   norm_status_type norm_status;
   unit_type        unit_x, unit_y, unit_z;
   logic            row_push;
   row_type         row;
   logic            queue_full;
   row_type         head;

   lav_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .eye_x(req_eye_x), .eye_y(req_eye_y), .eye_z(req_eye_z),
      .target_x(req_target_x), .target_y(req_target_y), .target_z(req_target_z),
      .up_x(req_up_x), .up_y(req_up_y), .up_z(req_up_z),
      .item_valid(item_valid), .item(item), .item_take(item_take)
   );

   lav_norm u_norm (
      .clock(clock), .reset(reset), .start(norm_start),
      .vec_x(norm_x), .vec_y(norm_y), .vec_z(norm_z),
      .status(norm_status), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z)
   );

   lav_back u_back (
      .clock(clock), .reset(reset), .item_valid(item_valid), .item(item),
      .item_take(item_take), .norm_start(norm_start),
      .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
      .norm_status(norm_status), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
      .row_push(row_push), .row(row), .queue_full(queue_full)
   );

   lav_rspq u_rspq (
      .clock(clock), .reset(reset), .row_push(row_push), .row_in(row),
      .queue_full(queue_full), .pop(pop), .empty(empty), .head(head)
   );

   assign rsp_row_index = head.row_index;
   assign rsp_axis_x = head.axis_x;
   assign rsp_axis_y = head.axis_y;
   assign rsp_axis_z = head.axis_z;
   assign rsp_offset = head.offset;
   assign rsp_degenerate = head.degenerate;
   assign rsp_last = head.last;

endmodule

### rtl/lav_checker.sv
// Port-level checks of the look-at view matrix block and their binding.
module lav_port_checks import lav_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input logic [1:0]        rsp_row_index,
   input logic [AXIS_W-1:0] rsp_axis_x,
   input logic [AXIS_W-1:0] rsp_axis_y,
   input logic [AXIS_W-1:0] rsp_axis_z,
   input logic [31:0]       rsp_offset,
   input logic              rsp_degenerate,
   input logic              rsp_last
);

   a_reset_clears: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_held_row: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_offset) && $stable(rsp_row_index)))
      else $error("waiting result beat changed");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last == (rsp_row_index == ROW_BACK)))
      else $error("last flag does not match the back row");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_degenerate) |-> (rsp_axis_x == '0 && rsp_axis_y == '0 &&
                                      rsp_axis_z == '0 && rsp_offset == 32'd0))
      else $error("degenerate row carries nonzero data");

endmodule

bind look_at_view_matrix lav_port_checks u_lav_port_checks (.*);

### sim/lav_checker.sv
// Checker that predicts the view matrix rows of each request and compares them with the results.
module lav_checker import lav_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  logic [31:0]       req_eye_x,
   input  logic [31:0]       req_eye_y,
   input  logic [31:0]       req_eye_z,
   input  logic [31:0]       req_target_x,
   input  logic [31:0]       req_target_y,
   input  logic [31:0]       req_target_z,
   input  logic [31:0]       req_up_x,
   input  logic [31:0]       req_up_y,
   input  logic [31:0]       req_up_z,
   input  logic              empty,
   input  logic              pop,
   input  logic [1:0]        rsp_row_index,
   input  logic [AXIS_W-1:0] rsp_axis_x,
   input  logic [AXIS_W-1:0] rsp_axis_y,
   input  logic [AXIS_W-1:0] rsp_axis_z,
   input  logic [31:0]       rsp_offset,
   input  logic              rsp_degenerate,
   input  logic              rsp_last,
   output int                failures,
   output int                rows_pending
);

   typedef longint signed vec3_type [3];

   row_type expected_rows[$];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   // Returns 0 for a zero vector, otherwise the unit vector in u.
   function automatic bit to_unit(vec3_type v, output vec3_type u);
      longint unsigned mag[3];
      longint unsigned peak, sum, len, q;
      bit neg[3];
      peak = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'd0 - 64'(v[i]) : 64'(v[i]);
         if (mag[i] > peak) peak = mag[i];
         u[i] = 0;
      end
      if (peak == 0) return 0;
      while (peak >= (64'd1 << 30)) begin
         peak >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (peak < (64'd1 << 29)) begin
         peak <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FRAC_BITS) + len / 2) / len;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic vec3_type cross3(vec3_type a, vec3_type b);
      vec3_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   function automatic logic [AXIS_W-1:0] clamp_axis(longint signed v);
      if (v > AXIS_MAX) v = AXIS_MAX;
      if (v < AXIS_MIN) v = AXIS_MIN;
      return v[AXIS_W-1:0];
   endfunction

   function automatic logic [31:0] eye_offset(vec3_type a, vec3_type e);
      longint signed s;
      s = a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
      s = -((s + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      if (s > OFFSET_MAX) s = OFFSET_MAX;
      if (s < OFFSET_MIN) s = OFFSET_MIN;
      return s[31:0];
   endfunction

   task automatic predict_rows();
      vec3_type eye, up, back, right, upward, tmp;
      vec3_type basis [3];
      row_type r;
      bit ok;
      eye = '{longint'(signed'(req_eye_x)), longint'(signed'(req_eye_y)),
              longint'(signed'(req_eye_z))};
      up = '{longint'(signed'(req_up_x)), longint'(signed'(req_up_y)),
             longint'(signed'(req_up_z))};
      tmp = '{eye[0] - longint'(signed'(req_target_x)), eye[1] - longint'(signed'(req_target_y)),
              eye[2] - longint'(signed'(req_target_z))};
      ok = to_unit(tmp, back);
      if (ok) ok = to_unit(cross3(up, back), right);
      if (ok) ok = to_unit(cross3(back, right), upward);
      basis[0] = right;
      basis[1] = upward;
      basis[2] = back;
      for (int k = 0; k < 3; k++) begin
         r = '0;
         r.row_index = (k == 0) ? ROW_RIGHT : (k == 1) ? ROW_UP : ROW_BACK;
         r.last = (k == 2);
         if (ok) begin
            r.axis_x = clamp_axis(basis[k][0]);
            r.axis_y = clamp_axis(basis[k][1]);
            r.axis_z = clamp_axis(basis[k][2]);
            r.offset = eye_offset(basis[k], eye);
         end else begin
            r.degenerate = 1'b1;
         end
         expected_rows.push_back(r);
      end
   endtask

   task automatic check_row();
      row_type e;
      if (expected_rows.size() == 0) begin
         $error("result beat with no expected row");
         failures++;
         return;
      end
      e = expected_rows.pop_front();
      if (rsp_row_index !== e.row_index) begin
         $error("row_index expected %0d actual %0d", e.row_index, rsp_row_index);
         failures++;
      end
      if (rsp_axis_x !== e.axis_x) begin
         $error("axis_x expected %0d actual %0d", $signed(e.axis_x), $signed(rsp_axis_x));
         failures++;
      end
      if (rsp_axis_y !== e.axis_y) begin
         $error("axis_y expected %0d actual %0d", $signed(e.axis_y), $signed(rsp_axis_y));
         failures++;
      end
      if (rsp_axis_z !== e.axis_z) begin
         $error("axis_z expected %0d actual %0d", $signed(e.axis_z), $signed(rsp_axis_z));
         failures++;
      end
      if (rsp_offset !== e.offset) begin
         $error("offset expected %0d actual %0d", $signed(e.offset), $signed(rsp_offset));
         failures++;
      end
      if (rsp_degenerate !== e.degenerate) begin
         $error("degenerate expected %0d actual %0d", e.degenerate, rsp_degenerate);
         failures++;
      end
      if (rsp_last !== e.last) begin
         $error("last expected %0d actual %0d", e.last, rsp_last);
         failures++;
      end
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) check_row();
         if (push && !full) predict_rows();
      end
      rows_pending <= expected_rows.size();
   end

   initial rows_pending = 0;

endmodule

### sim/tb.sv
// Top of the look-at view matrix testbench: clock, reset, request and result traffic, verdict.
module tb;
   import lav_pkg::*;

   logic clock;
   logic reset;
   logic push, full, empty, pop;
   logic [31:0] req_eye_x, req_eye_y, req_eye_z;
   logic [31:0] req_target_x, req_target_y, req_target_z;
   logic [31:0] req_up_x, req_up_y, req_up_z;
   logic [1:0] rsp_row_index;
   logic [AXIS_W-1:0] rsp_axis_x, rsp_axis_y, rsp_axis_z;
   logic [31:0] rsp_offset;
   logic rsp_degenerate, rsp_last;
   int failures, rows_pending;
   bit burst_mode;

   look_at_view_matrix dut (.*);
   lav_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

   // Sends one request beat; push stays high when the next beat follows at once.
   task automatic send_view(input logic [31:0] e[3], input logic [31:0] t[3],
                            input logic [31:0] u[3]);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_eye_x <= e[0]; req_eye_y <= e[1]; req_eye_z <= e[2];
      req_target_x <= t[0]; req_target_y <= t[1]; req_target_z <= t[2];
      req_up_x <= u[0]; req_up_y <= u[1]; req_up_z <= u[2];
      do @(posedge clock); while (full);
   endtask

   function automatic logic [31:0] pick_coord(int kind);
      case (kind)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   initial begin
      int gap;
      pop = 1'b0;
      wait (!reset);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   initial begin
      logic [31:0] e[3], t[3], u[3];
      int kind, waited;
      localparam logic [31:0] ONE = 32'h0001_0000;
      localparam logic [31:0] MAXV = 32'h7fff_ffff;
      localparam logic [31:0] MINV = 32'h8000_0000;
      burst_mode = 0;
      reset = 1'b1;
      push = 1'b0;
      {req_eye_x, req_eye_y, req_eye_z, req_target_x, req_target_y, req_target_z} = '0;
      {req_up_x, req_up_y, req_up_z} = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A plain camera, then eye equal to target, a zero up, up along the view, and eye and target both zero.
      send_view('{0, 0, 5 * ONE}, '{0, 0, 0}, '{0, ONE, 0});
      send_view('{3 * ONE, ONE, 2 * ONE}, '{3 * ONE, ONE, 2 * ONE}, '{0, ONE, 0});
      send_view('{ONE, 2 * ONE, 3 * ONE}, '{0, 0, 0}, '{0, 0, 0});
      send_view('{0, 4 * ONE, 0}, '{0, 0, 0}, '{0, ONE, 0});
      send_view('{0, 0, 0}, '{0, 0, 0}, '{ONE, ONE, ONE});
      // Full-range extremes: the eye-minus-target difference needs 33 bits.
      send_view('{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV}, '{0, ONE, 0});
      send_view('{MINV, MAXV, MINV}, '{MAXV, MINV, 0}, '{MAXV, MINV, MAXV});
      send_view('{MAXV, 0, MINV}, '{0, MINV, MAXV}, '{MINV, MINV, MINV});
      send_view('{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV}, '{1, 0, 0});
      send_view('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
      send_view('{32'hffff_ffff, 0, 0}, '{0, 0, 0}, '{0, 0, 32'hffff_ffff});
      send_view('{MAXV, MAXV, MAXV}, '{0, 0, 0}, '{ONE, 0, 0});
      send_view('{5 * ONE, 5 * ONE, 5 * ONE}, '{0, 0, 0}, '{MAXV, MAXV, MAXV});
      send_view('{ONE, ONE, ONE}, '{ONE, ONE, 0}, '{ONE, 0, 0});
      send_view('{100 * ONE, -3 * ONE, 7 * ONE}, '{2 * ONE, 5 * ONE, -9 * ONE},
                '{0, ONE, 0});

      for (int n = 0; n < 380; n++) begin
         if (n % 50 == 0) burst_mode = !burst_mode && (n % 100 == 50);
         kind = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            e[i] = pick_coord(kind);
            t[i] = pick_coord(kind);
            u[i] = pick_coord($urandom_range(0, 2));
         end
         case ($urandom_range(0, 15))
            0: t = e;
            1: for (int i = 0; i < 3; i++) u[i] = e[i] - t[i];
            2: u = '{0, 0, 0};
            3: u = '{0, ONE, 0};
            default: ;
         endcase
         send_view(e, t, u);
      end
      push <= 1'b0;
      burst_mode = 0;

      waited = 0;
      while (rows_pending != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (1000) @(posedge clock);
      if (failures == 0 && rows_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lav_pkg.sv
rtl/lav_front.sv
rtl/lav_norm.sv
rtl/lav_back.sv
rtl/lav_rspq.sv
rtl/look_at_view_matrix.sv
rtl/lav_checker.sv
sim/lav_checker.sv
sim/tb.sv
